### hw/rtl/i2cscr_pkg.sv
// Shared types and constants for the I2C sensor command/read master.
package i2cscr_pkg;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_COMMAND = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_ADDR  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_ADDR   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_TIMEOUT = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] WRITE_ADDR_RESET  = 8'd70;
   localparam logic [7:0] READ_ADDR_RESET   = 8'd71;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   // Bus phase codes; each bit of a byte takes a low and a high phase.
   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_START  = 5'd1,
      PH_AD_LO  = 5'd2,
      PH_AD_HI  = 5'd3,
      PH_ADK_LO = 5'd4,
      PH_ADK_HI = 5'd5,
      PH_CM_LO  = 5'd6,
      PH_CM_HI  = 5'd7,
      PH_CMK_LO = 5'd8,
      PH_CMK_HI = 5'd9,
      PH_RH_LO  = 5'd10,
      PH_RH_HI  = 5'd11,
      PH_MA_LO  = 5'd12,
      PH_MA_HI  = 5'd13,
      PH_RL_LO  = 5'd14,
      PH_RL_HI  = 5'd15,
      PH_NA_LO  = 5'd16,
      PH_NA_HI  = 5'd17,
      PH_SP_LO  = 5'd18,
      PH_SP_HI  = 5'd19,
      PH_SP_END = 5'd20,
      PH_RS_LO  = 5'd21,
      PH_RS_HI  = 5'd22,
      PH_RS_END = 5'd23
   } phase_type;

   // One request item.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] command_byte;
      logic       sda_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic        busy_res;
      logic        done_res;
      logic        ack_error;
      logic [15:0] read_value;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [7:0] write_address_byte;
      logic [7:0] read_address_byte;
      logic [7:0] ack_timeout_ticks;
   } csr_type;

endpackage

### hw/rtl/i2cscr_if.sv
// Valid/ready channel interfaces for requests and results.
interface i2cscr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] command_byte;
   logic       sda_in;

   modport source (output valid, output op, output command_byte, output sda_in, input ready);
   modport sink (input valid, input op, input command_byte, input sda_in, output ready);
endinterface

interface i2cscr_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_level;
   logic        sda_level;
   logic        busy_res;
   logic        done_res;
   logic        ack_error;
   logic [15:0] read_value;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output done_res, output ack_error, output read_value, input ready);
   modport sink (input valid, input scl_level, input sda_level, input busy_res,
                 input done_res, input ack_error, input read_value, output ready);
endinterface

### hw/rtl/i2cscr_csr.sv
// Configuration registers: bus addresses and acknowledge timeout.
module i2cscr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [i2cscr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cscr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output i2cscr_pkg::csr_type                 csr_out
);

   i2cscr_pkg::csr_type csr_ff;

   // Register writes by index; unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.write_address_byte <= i2cscr_pkg::WRITE_ADDR_RESET;
         csr_ff.read_address_byte  <= i2cscr_pkg::READ_ADDR_RESET;
         csr_ff.ack_timeout_ticks  <= i2cscr_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cscr_pkg::CSR_WRITE_ADDR:  csr_ff.write_address_byte <= csr_wdata;
            i2cscr_pkg::CSR_READ_ADDR:   csr_ff.read_address_byte  <= csr_wdata;
            i2cscr_pkg::CSR_ACK_TIMEOUT: csr_ff.ack_timeout_ticks  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_out = csr_ff;

endmodule

### hw/rtl/i2cscr_engine.sv
// Bus phase sequencer: each tick drives one phase and forms that tick's result.
module i2cscr_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cscr_pkg::req_type item,
   input  i2cscr_pkg::csr_type csr,
   output i2cscr_pkg::rsp_type result
);

   i2cscr_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  wait_ff, wait_in;
   logic        kind_ff, kind_in;
   logic [7:0]  saved_ff, saved_in;
   logic [15:0] read_buf_ff, read_buf_in;
   logic        err_ff, err_in;

   // Phase logic for the current tick.
   always_comb begin
      i2cscr_pkg::phase_type cur;
      logic ack_ok;
      logic ack_fail;

      cur          = phase_ff;
      kind_in      = kind_ff;
      saved_in     = saved_ff;
      err_in       = err_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      read_buf_in  = read_buf_ff;

      // An operation is taken only from idle; its first tick drives START.
      if (phase_ff == i2cscr_pkg::PH_IDLE &&
          (item.op == i2cscr_pkg::OP_COMMAND || item.op == i2cscr_pkg::OP_READ)) begin
         kind_in = (item.op == i2cscr_pkg::OP_READ);
         if (item.op == i2cscr_pkg::OP_COMMAND) begin
            saved_in = item.command_byte;
         end
         err_in = 1'b0;
         cur    = i2cscr_pkg::PH_START;
      end

      // Acknowledge sample: low SDA acknowledges, otherwise count toward timeout.
      ack_ok   = ~item.sda_in;
      ack_fail = item.sda_in && (wait_ff >= csr.ack_timeout_ticks);

      phase_in          = cur;
      result.scl_level  = 1'b1;
      result.sda_level  = 1'b1;
      result.busy_res   = 1'b1;
      result.done_res   = 1'b0;
      result.ack_error  = 1'b0;

      case (cur)
         i2cscr_pkg::PH_IDLE: begin
            result.busy_res = 1'b0;
         end
         i2cscr_pkg::PH_START: begin
            result.sda_level = 1'b0;
            shift_in     = kind_in ? csr.read_address_byte : csr.write_address_byte;
            bit_count_in = 4'd0;
            phase_in     = i2cscr_pkg::PH_AD_LO;
         end
         i2cscr_pkg::PH_AD_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = shift_ff[7];
            phase_in = i2cscr_pkg::PH_AD_HI;
         end
         i2cscr_pkg::PH_CM_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = shift_ff[7];
            phase_in = i2cscr_pkg::PH_CM_HI;
         end
         i2cscr_pkg::PH_AD_HI: begin
            result.sda_level = shift_ff[7];
            shift_in     = {shift_ff[6:0], 1'b0};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = bit_count_in[3] ? i2cscr_pkg::PH_ADK_LO : i2cscr_pkg::PH_AD_LO;
         end
         i2cscr_pkg::PH_CM_HI: begin
            result.sda_level = shift_ff[7];
            shift_in     = {shift_ff[6:0], 1'b0};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = bit_count_in[3] ? i2cscr_pkg::PH_CMK_LO : i2cscr_pkg::PH_CM_LO;
         end
         i2cscr_pkg::PH_ADK_LO: begin
            result.scl_level = 1'b0;
            wait_in  = 8'd0;
            phase_in = i2cscr_pkg::PH_ADK_HI;
         end
         i2cscr_pkg::PH_CMK_LO: begin
            result.scl_level = 1'b0;
            wait_in  = 8'd0;
            phase_in = i2cscr_pkg::PH_CMK_HI;
         end
         i2cscr_pkg::PH_ADK_HI: begin
            bit_count_in = 4'd0;
            if (ack_ok) begin
               if (kind_ff) begin
                  phase_in = i2cscr_pkg::PH_RH_LO;
               end else begin
                  shift_in = saved_ff;
                  phase_in = i2cscr_pkg::PH_CM_LO;
               end
            end else if (ack_fail) begin
               // A read gives up; a command write retries with a fresh START.
               if (kind_ff) begin
                  err_in   = 1'b1;
                  phase_in = i2cscr_pkg::PH_SP_LO;
               end else begin
                  phase_in = i2cscr_pkg::PH_RS_LO;
               end
            end else begin
               wait_in = wait_ff + 8'd1;
            end
         end
         i2cscr_pkg::PH_CMK_HI: begin
            if (ack_ok) begin
               phase_in = i2cscr_pkg::PH_SP_LO;
            end else if (ack_fail) begin
               err_in   = 1'b1;
               phase_in = i2cscr_pkg::PH_SP_LO;
            end else begin
               wait_in = wait_ff + 8'd1;
            end
         end
         i2cscr_pkg::PH_RH_LO: begin
            result.scl_level = 1'b0;
            phase_in = i2cscr_pkg::PH_RH_HI;
         end
         i2cscr_pkg::PH_RL_LO: begin
            result.scl_level = 1'b0;
            phase_in = i2cscr_pkg::PH_RL_HI;
         end
         i2cscr_pkg::PH_RH_HI: begin
            shift_in     = {shift_ff[6:0], item.sda_in};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = bit_count_in[3] ? i2cscr_pkg::PH_MA_LO : i2cscr_pkg::PH_RH_LO;
         end
         i2cscr_pkg::PH_RL_HI: begin
            shift_in     = {shift_ff[6:0], item.sda_in};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = bit_count_in[3] ? i2cscr_pkg::PH_NA_LO : i2cscr_pkg::PH_RL_LO;
         end
         i2cscr_pkg::PH_MA_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
            phase_in = i2cscr_pkg::PH_MA_HI;
         end
         i2cscr_pkg::PH_MA_HI: begin
            // Master acknowledge; the high byte is parked until the low byte is in.
            result.sda_level = 1'b0;
            saved_in     = shift_ff;
            bit_count_in = 4'd0;
            phase_in     = i2cscr_pkg::PH_RL_LO;
         end
         i2cscr_pkg::PH_NA_LO: begin
            result.scl_level = 1'b0;
            phase_in = i2cscr_pkg::PH_NA_HI;
         end
         i2cscr_pkg::PH_NA_HI: begin
            read_buf_in = {saved_ff, shift_ff};
            phase_in    = i2cscr_pkg::PH_SP_LO;
         end
         i2cscr_pkg::PH_SP_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
            phase_in = i2cscr_pkg::PH_SP_HI;
         end
         i2cscr_pkg::PH_RS_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
            phase_in = i2cscr_pkg::PH_RS_HI;
         end
         i2cscr_pkg::PH_SP_HI: begin
            result.sda_level = 1'b0;
            phase_in = i2cscr_pkg::PH_SP_END;
         end
         i2cscr_pkg::PH_RS_HI: begin
            result.sda_level = 1'b0;
            phase_in = i2cscr_pkg::PH_RS_END;
         end
         i2cscr_pkg::PH_SP_END: begin
            result.done_res  = 1'b1;
            result.ack_error = err_ff;
            phase_in = i2cscr_pkg::PH_IDLE;
         end
         i2cscr_pkg::PH_RS_END: begin
            phase_in = i2cscr_pkg::PH_START;
         end
         default: begin
            result.busy_res = 1'b0;
            phase_in = i2cscr_pkg::PH_IDLE;
         end
      endcase

      result.read_value = read_buf_in;
   end

   // State advances once per processed tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cscr_pkg::PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         wait_ff      <= 8'd0;
         kind_ff      <= 1'b0;
         saved_ff     <= 8'd0;
         read_buf_ff  <= 16'd0;
         err_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         kind_ff      <= kind_in;
         saved_ff     <= saved_in;
         read_buf_ff  <= read_buf_in;
         err_ff       <= err_in;
      end
   end

endmodule

### hw/rtl/i2c_sensor_command_read_master_top.sv
// Top level of the I2C sensor command/read master: input stage, sequencer, result register.
// Each request transfer is one bus phase tick and yields exactly one result transfer with
// the SCL/SDA levels for that tick, busy/done/error flags and the last 16-bit read value.
// The block takes one tick per clock while the result side keeps up: a tick is captured in
// the input register, runs through the phase sequencer and lands in the result register,
// with no stall between ticks. Configuration writes take effect on the next tick and
// should be made only while the bus is idle.
module i2c_sensor_command_read_master_top (
   input  logic                                   clock,
   input  logic                                   reset,
   i2cscr_req_if.sink                             req_bus,
   i2cscr_rsp_if.source                           rsp_bus,
   input  logic                                   csr_we,
   input  logic [i2cscr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cscr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                in_valid_ff;
   i2cscr_pkg::req_type in_item_ff;
   logic                out_valid_ff;
   i2cscr_pkg::rsp_type out_item_ff;
   i2cscr_pkg::rsp_type step_result;
   i2cscr_pkg::csr_type csr;
   logic                out_free;
   logic                step_en;

   // The result register frees when empty or when its transfer completes.
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step_en       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || step_en;

   i2cscr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_out   (csr)
   );

   i2cscr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .csr     (csr),
      .result  (step_result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.op           <= req_bus.op;
         in_item_ff.command_byte <= req_bus.command_byte;
         in_item_ff.sda_in       <= req_bus.sda_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step_en;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.scl_level  = out_item_ff.scl_level;
   assign rsp_bus.sda_level  = out_item_ff.sda_level;
   assign rsp_bus.busy_res   = out_item_ff.busy_res;
   assign rsp_bus.done_res   = out_item_ff.done_res;
   assign rsp_bus.ack_error  = out_item_ff.ack_error;
   assign rsp_bus.read_value = out_item_ff.read_value;

endmodule
